### hdl/json_key_value_extractor_top_defines.svh
// Assertion macros shared by the checker of the key/value extractor.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef JSON_KEY_VALUE_EXTRACTOR_TOP_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_TOP_DEFINES_SVH

// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define JKVE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define JKVE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/jkve_pkg.sv
// Types, character codes and result encodings for the key/value extractor.
// Used by every module of the block; depends on nothing.
package jkve_pkg;

  localparam int KEY_MAX_DEF = 16;
  localparam int VALUE_W     = 31;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int KEY_LEN_W   = 5;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;

  localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

  typedef enum logic [2:0] {
    PH_KEY,
    PH_COLON,
    PH_OPENQ,
    PH_STR,
    PH_WS,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_FOUND,
    KIND_NONE
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH,
    REG_KEY_LOW,
    REG_KEY_HIGH,
    REG_VALUE_MODE
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } result_t;

endpackage

### hdl/jkve_window.sv
// Window of the most recent document bytes and the quoted key compare.
// Depends on jkve_pkg; driven by the phase logic in jkve_fsm.
module jkve_window #(
  parameter int KEY_MAX = jkve_pkg::KEY_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  jkve_pkg::win_ctl_t             ctl,
  input  logic [7:0]                     doc_byte,
  input  logic [jkve_pkg::KEY_LEN_W-1:0] key_length,
  input  logic [8*KEY_MAX-1:0]           key_bytes,
  output logic                           match
);

  localparam int DEPTH = KEY_MAX + 2;
  localparam int IW    = $clog2(DEPTH);
  localparam int LW    = $clog2(KEY_MAX + 1);

  logic [7:0]    win      [DEPTH];
  logic [7:0]    win_next [DEPTH];
  logic [LW-1:0] len_c;
  logic [IW-1:0] open_idx;
  logic [IW-1:0] pos;
  logic          body_ok;

  always_comb begin
    for (int j = 0; j < DEPTH - 1; j++) begin
      win_next[j] = win[j + 1];
    end
    win_next[DEPTH-1] = doc_byte;
  end

  always_comb begin
    if (key_length > jkve_pkg::KEY_LEN_W'(KEY_MAX)) begin
      len_c = LW'(KEY_MAX);
    end else begin
      len_c = LW'(key_length);
    end
    open_idx = IW'(KEY_MAX - int'(len_c));
    body_ok  = 1'b1;
    pos      = '0;
    for (int i = 0; i < KEY_MAX; i++) begin
      if (i < int'(len_c)) begin
        pos = IW'(KEY_MAX + 1 - int'(len_c) + i);
        if (win_next[pos] != key_bytes[8*i +: 8]) begin
          body_ok = 1'b0;
        end
      end
    end
    match = body_ok && (win_next[open_idx] == jkve_pkg::CHAR_QUOTE) &&
            (win_next[DEPTH-1] == jkve_pkg::CHAR_QUOTE);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int j = 0; j < DEPTH; j++) begin
        win[j] <= '0;
      end
    end else if (ctl.shift) begin
      win <= win_next;
    end
  end

endmodule

### hdl/jkve_fsm.sv
// Phase sequencer: string and integer value parsing and the result of each word.
// Depends on jkve_pkg; takes the key match from jkve_window.
module jkve_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           doc_byte,
  input  logic                 doc_end,
  input  logic                 value_mode,
  input  logic                 match,
  output jkve_pkg::win_ctl_t   win_ctl,
  output jkve_pkg::result_t    res
);

  jkve_pkg::phase_t phase, phase_next;
  logic                         escape_pending, escape_pending_next;
  logic [jkve_pkg::VALUE_W-1:0] number_accum, number_accum_next;
  logic                         digit_seen, digit_seen_next;

  logic                         is_digit;
  logic                         is_space;
  logic [jkve_pkg::VALUE_W+3:0] acc_mul;
  logic [jkve_pkg::VALUE_W-1:0] acc_add;

  always_comb begin
    is_digit = doc_byte inside {[jkve_pkg::CHAR_ZERO:jkve_pkg::CHAR_NINE]};
    is_space = doc_byte inside {jkve_pkg::CHAR_SPACE, [jkve_pkg::CHAR_TAB:jkve_pkg::CHAR_CR]};
    acc_mul  = ((jkve_pkg::VALUE_W+4)'(number_accum) << 3) +
               ((jkve_pkg::VALUE_W+4)'(number_accum) << 1) +
               (jkve_pkg::VALUE_W+4)'(doc_byte[3:0]);
    if (acc_mul > (jkve_pkg::VALUE_W+4)'(jkve_pkg::NUM_MAX)) begin
      acc_add = jkve_pkg::NUM_MAX;
    end else begin
      acc_add = acc_mul[jkve_pkg::VALUE_W-1:0];
    end
  end

  assign win_ctl.shift = accept && (phase == jkve_pkg::PH_KEY);
  assign win_ctl.clear = accept && doc_end;

  always_comb begin
    phase_next          = phase;
    escape_pending_next = escape_pending;
    number_accum_next   = number_accum;
    digit_seen_next     = digit_seen;
    case (phase)
      jkve_pkg::PH_KEY: begin
        if (match) begin
          phase_next = jkve_pkg::PH_COLON;
        end
      end
      jkve_pkg::PH_COLON: begin
        if (doc_byte == jkve_pkg::CHAR_COLON) begin
          phase_next = value_mode ? jkve_pkg::PH_WS : jkve_pkg::PH_OPENQ;
        end
      end
      jkve_pkg::PH_OPENQ: begin
        if (doc_byte == jkve_pkg::CHAR_QUOTE) begin
          phase_next = jkve_pkg::PH_STR;
        end
      end
      jkve_pkg::PH_STR: begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
        end else if (doc_byte == jkve_pkg::CHAR_BSLASH) begin
          escape_pending_next = 1'b1;
        end else if (doc_byte == jkve_pkg::CHAR_QUOTE) begin
          phase_next = jkve_pkg::PH_DONE;
        end
      end
      jkve_pkg::PH_WS: begin
        if (is_digit) begin
          number_accum_next = acc_add;
          digit_seen_next   = 1'b1;
          phase_next        = jkve_pkg::PH_DIGITS;
        end else if (!is_space) begin
          phase_next = jkve_pkg::PH_DONE;
        end
      end
      jkve_pkg::PH_DIGITS: begin
        if (is_digit) begin
          number_accum_next = acc_add;
          digit_seen_next   = 1'b1;
        end else begin
          phase_next = jkve_pkg::PH_DONE;
        end
      end
      default: begin
        phase_next = jkve_pkg::PH_DONE;
      end
    endcase
    if (doc_end) begin
      phase_next          = jkve_pkg::PH_KEY;
      escape_pending_next = 1'b0;
      number_accum_next   = '0;
      digit_seen_next     = 1'b0;
    end
  end

  always_comb begin
    res.valid = 1'b0;
    res.kind  = jkve_pkg::KIND_BYTE;
    res.value = '0;
    res.last  = 1'b0;
    case (phase)
      jkve_pkg::PH_STR: begin
        if (escape_pending) begin
          res.valid = 1'b1;
          res.value = jkve_pkg::VALUE_W'(doc_byte);
        end else if (doc_byte == jkve_pkg::CHAR_QUOTE) begin
          res.valid = 1'b1;
          res.kind  = jkve_pkg::KIND_FOUND;
          res.last  = 1'b1;
        end else if (doc_byte != jkve_pkg::CHAR_BSLASH) begin
          res.valid = 1'b1;
          res.value = jkve_pkg::VALUE_W'(doc_byte);
        end
      end
      jkve_pkg::PH_WS: begin
        if (!is_digit && !is_space) begin
          res.valid = 1'b1;
          res.kind  = jkve_pkg::KIND_NONE;
          res.last  = 1'b1;
        end
      end
      jkve_pkg::PH_DIGITS: begin
        if (!is_digit) begin
          res.valid = 1'b1;
          res.kind  = jkve_pkg::KIND_FOUND;
          res.value = number_accum;
          res.last  = 1'b1;
        end
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
    if (doc_end && (phase != jkve_pkg::PH_DONE) && !(res.valid && res.last)) begin
      res.valid = 1'b1;
      res.last  = 1'b1;
      if (((phase == jkve_pkg::PH_WS) || (phase == jkve_pkg::PH_DIGITS)) && is_digit) begin
        res.kind  = jkve_pkg::KIND_FOUND;
        res.value = acc_add;
      end else begin
        res.kind  = jkve_pkg::KIND_NONE;
        res.value = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= jkve_pkg::PH_KEY;
      escape_pending <= 1'b0;
      number_accum   <= '0;
      digit_seen     <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      number_accum   <= number_accum_next;
      digit_seen     <= digit_seen_next;
    end
  end

endmodule

### hdl/json_key_value_extractor_top.sv
// Output: a result word is in the output register in the cycle after its byte is accepted.
// Throughput: one document byte per cycle; the byte is taken while the output register
// is empty or being drained in the same cycle, so only a stalled result holds input.
// Reset: synchronous rst clears the parse state, the byte window and the output valid,
// and returns the registers to key length 1, zero key bytes and string mode.
module json_key_value_extractor_top #(
  parameter int KEY_MAX = jkve_pkg::KEY_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] doc_byte
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [30:0] result_value, [31] zero
  output logic [1:0]                      m_tuser,   // [1:0] result_kind
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [jkve_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jkve_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [jkve_pkg::KEY_LEN_W-1:0]  key_length;
  logic [jkve_pkg::CFG_DATA_W-1:0] key_low_bytes;
  logic [jkve_pkg::CFG_DATA_W-1:0] key_high_bytes;
  logic                            value_mode;
  logic [2*jkve_pkg::CFG_DATA_W-1:0] key_all;

  logic               accept;
  logic               match;
  jkve_pkg::win_ctl_t win_ctl;
  jkve_pkg::result_t  res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign key_all   = {key_high_bytes, key_low_bytes};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length     <= jkve_pkg::KEY_LEN_W'(1);
      key_low_bytes  <= '0;
      key_high_bytes <= '0;
      value_mode     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jkve_pkg::REG_KEY_LENGTH: key_length     <= cfg_data[jkve_pkg::KEY_LEN_W-1:0];
        jkve_pkg::REG_KEY_LOW:    key_low_bytes  <= cfg_data;
        jkve_pkg::REG_KEY_HIGH:   key_high_bytes <= cfg_data;
        jkve_pkg::REG_VALUE_MODE: value_mode     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  jkve_window #(
    .KEY_MAX (KEY_MAX)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (win_ctl),
    .doc_byte   (s_tdata),
    .key_length (key_length),
    .key_bytes  (key_all[8*KEY_MAX-1:0]),
    .match      (match)
  );

  jkve_fsm u_fsm (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .doc_byte   (s_tdata),
    .doc_end    (s_tlast),
    .value_mode (value_mode),
    .match      (match),
    .win_ctl    (win_ctl),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_tdata <= {1'b0, res.value};
      m_tuser <= res.kind;
      m_tlast <= res.last;
    end
  end

endmodule

### hdl/jkve_checker.sv
// Port-level checks on the key/value extractor and the bind that attaches them.
// Depends on jkve_pkg and json_key_value_extractor_top_defines.svh.
`include "json_key_value_extractor_top_defines.svh"

module jkve_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  `JKVE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled word changed")
  `JKVE_ASSERT_NOW(a_byte, m_tvalid && (m_tuser == jkve_pkg::KIND_BYTE), !m_tlast && (m_tdata[31:8] == 24'd0), "string byte word malformed")
  `JKVE_ASSERT_NOW(a_term, m_tvalid && ((m_tuser == jkve_pkg::KIND_FOUND) || (m_tuser == jkve_pkg::KIND_NONE)), m_tlast, "terminal word without last")
  `JKVE_ASSERT_NOW(a_none, m_tvalid && (m_tuser == jkve_pkg::KIND_NONE), (m_tdata == 32'd0) && (m_tuser != 2'd3), "not found word carries a value")

endmodule

bind json_key_value_extractor_top jkve_checker u_jkve_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
